/* hw/rtl/cdpc_pkg.sv */
// ----------------------------------------------------------------------------
// cdpc_pkg
// Shared types and codes for the circular byte deque with palindrome check.
// ----------------------------------------------------------------------------
package cdpc_pkg;

    localparam int DEPTH_DEF = 16;

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byte_in;
    } req_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [1:0] status;
        logic       is_palindrome;
        logic [4:0] fill_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_CHK_RD,
        S_CHK_CMP
    } state_t;

    typedef enum logic [2:0] {
        RES_DONE,
        RES_FULL,
        RES_EMPTY,
        RES_POPPED,
        RES_CHECK
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      push_front;
        logic      push_back;
        logic      rd_front;
        logic      rd_back;
        logic      chk_rd;
        logic      chk_cmp;
        logic      chk_clear;
        logic      commit;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       ge2;
    } sts_t;

endpackage

/* hw/rtl/circular_deque_with_palindrome_check_core.sv */
// ----------------------------------------------------------------------------
// circular_deque_with_palindrome_check_core
// Byte deque in a ring buffer with push/pop at both ends and a palindrome
// check that drains the queue.
// ----------------------------------------------------------------------------
//  channel  | valid     | stall     | payload
//  request  | req_valid | req_stall | req (cdpc_pkg::req_t: op, byte_in)
//  response | rsp_valid | rsp_stall | rsp (cdpc_pkg::rsp_t)
//
//  Push, pop on empty and unused codes commit from S_EXEC; a pop commits
//  from S_POP_WAIT, after the registered store read.
//  Check: a read-then-compare loop over the store's two read ports, one
//  pair per loop, while two or more entries remain.
//  One request in flight; a new request is taken while a response waits.
//  Reset clears head, tail and count; store contents are not cleared.
//  rsp_stall only delays the final commit; internal work does not restart.
// ----------------------------------------------------------------------------
module circular_deque_with_palindrome_check_core
#(
    parameter int DEPTH = cdpc_pkg::DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cdpc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cdpc_pkg::rsp_t rsp
);

    cdpc_pkg::cmd_t cmd;
    cdpc_pkg::sts_t sts;

    cdpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cdpc_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

/* hw/rtl/cdpc_ctrl.sv */
// ----------------------------------------------------------------------------
// cdpc_ctrl
// Sequencer: takes one request at a time, steers the datapath, owns rsp_valid.
// ----------------------------------------------------------------------------
module cdpc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  cdpc_pkg::sts_t sts,
    output cdpc_pkg::cmd_t cmd
);

    cdpc_pkg::state_t state_reg;
    cdpc_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != cdpc_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdpc_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = cdpc_pkg::S_EXEC;
            end
            cdpc_pkg::S_EXEC:
            begin
                unique case (sts.op)
                    cdpc_pkg::OP_POP_FRONT, cdpc_pkg::OP_POP_BACK:
                    begin
                        if (!sts.empty)
                            state_next = cdpc_pkg::S_POP_WAIT;
                        else if (out_free)
                            state_next = cdpc_pkg::S_IDLE;
                    end
                    cdpc_pkg::OP_CHECK:
                        state_next = cdpc_pkg::S_CHK_RD;
                    default:
                    begin
                        if (out_free)
                            state_next = cdpc_pkg::S_IDLE;
                    end
                endcase
            end
            cdpc_pkg::S_POP_WAIT:
            begin
                if (out_free)
                    state_next = cdpc_pkg::S_IDLE;
            end
            cdpc_pkg::S_CHK_RD:
            begin
                if (sts.ge2)
                    state_next = cdpc_pkg::S_CHK_CMP;
                else if (out_free)
                    state_next = cdpc_pkg::S_IDLE;
            end
            cdpc_pkg::S_CHK_CMP:
                state_next = cdpc_pkg::S_CHK_RD;
            default:
                state_next = cdpc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.kind = cdpc_pkg::RES_DONE;
        unique case (state_reg)
            cdpc_pkg::S_IDLE:
                cmd.load_in = req_valid;
            cdpc_pkg::S_EXEC:
            begin
                unique case (sts.op)
                    cdpc_pkg::OP_PUSH_FRONT, cdpc_pkg::OP_PUSH_BACK:
                    begin
                        cmd.commit = out_free;
                        if (sts.full)
                            cmd.kind = cdpc_pkg::RES_FULL;
                        else
                        begin
                            cmd.push_front = out_free && (sts.op == cdpc_pkg::OP_PUSH_FRONT);
                            cmd.push_back  = out_free && (sts.op == cdpc_pkg::OP_PUSH_BACK);
                        end
                    end
                    cdpc_pkg::OP_POP_FRONT, cdpc_pkg::OP_POP_BACK:
                    begin
                        if (sts.empty)
                        begin
                            cmd.commit = out_free;
                            cmd.kind   = cdpc_pkg::RES_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_front = (sts.op == cdpc_pkg::OP_POP_FRONT);
                            cmd.rd_back  = (sts.op == cdpc_pkg::OP_POP_BACK);
                        end
                    end
                    cdpc_pkg::OP_CHECK:
                        ;
                    default:
                        cmd.commit = out_free;
                endcase
            end
            cdpc_pkg::S_POP_WAIT:
            begin
                cmd.commit = out_free;
                cmd.kind   = cdpc_pkg::RES_POPPED;
            end
            cdpc_pkg::S_CHK_RD:
            begin
                cmd.kind = cdpc_pkg::RES_CHECK;
                if (sts.ge2)
                    cmd.chk_rd = 1'b1;
                else
                begin
                    cmd.commit    = out_free;
                    cmd.chk_clear = out_free;
                end
            end
            cdpc_pkg::S_CHK_CMP:
                cmd.chk_cmp = 1'b1;
            default:
                ;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdpc_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // a result must never overwrite one still waiting downstream
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("commit while response slot occupied");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdpc_pkg::S_IDLE && req_valid) |=> (state_reg == cdpc_pkg::S_EXEC))
        else $error("accepted request not executed");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.commit))
        else $error("response valid without commit");

endmodule

/* hw/rtl/cdpc_dp.sv */
// ----------------------------------------------------------------------------
// cdpc_dp
// Ring-buffer store, head/tail/count registers, compare and response register.
// ----------------------------------------------------------------------------
module cdpc_dp
#(
    parameter int DEPTH = cdpc_pkg::DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cdpc_pkg::req_t req,
    input  cdpc_pkg::cmd_t cmd,
    output cdpc_pkg::sts_t sts,
    output cdpc_pkg::rsp_t rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [2:0]    op_reg;
    logic [7:0]    byte_reg;
    logic          same_reg;
    logic [7:0]    rd_a_reg;
    logic [7:0]    rd_b_reg;
    cdpc_pkg::rsp_t rsp_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [IW-1:0] wr_addr, rd_addr_a;
    logic          wr_en, rd_en;
    cdpc_pkg::rsp_t res;

    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;

    assign sts.op    = op_reg;
    assign sts.full  = (count_reg == CNT_FULL);
    assign sts.empty = (count_reg == '0);
    assign sts.ge2   = (count_reg >= CW'(2));

    assign wr_en     = cmd.push_front || cmd.push_back;
    assign wr_addr   = cmd.push_front ? head_dec : tail_reg;
    assign rd_en     = cmd.rd_front || cmd.rd_back || cmd.chk_rd;
    assign rd_addr_a = cmd.rd_back ? tail_dec : head_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        priority if (cmd.chk_clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.push_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.push_back)
        begin
            tail_next  = tail_inc;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rd_front)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        else if (cmd.rd_back)
        begin
            tail_next  = tail_dec;
            count_next = count_reg - 1'b1;
        end
        else if (cmd.chk_rd)
        begin
            head_next  = head_inc;
            tail_next  = tail_dec;
            count_next = count_reg - CW'(2);
        end
        else
        begin
            head_next  = head_reg;
            tail_next  = tail_reg;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        res.byte_out      = (cmd.kind == cdpc_pkg::RES_POPPED) ? rd_a_reg : 8'd0;
        res.is_palindrome = (cmd.kind == cdpc_pkg::RES_CHECK) ? same_reg : 1'b0;
        res.fill_count    = 5'(count_next);
        unique case (cmd.kind)
            cdpc_pkg::RES_FULL:  res.status = cdpc_pkg::ST_FULL;
            cdpc_pkg::RES_EMPTY: res.status = cdpc_pkg::ST_EMPTY;
            default:             res.status = cdpc_pkg::ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= req.op;
            byte_reg <= req.byte_in;
        end
        if (cmd.load_in)
            same_reg <= 1'b1;
        else if (cmd.chk_cmp)
            same_reg <= same_reg && (rd_a_reg == rd_b_reg);
        if (cmd.commit)
            rsp_reg <= res;
    end

    // byte store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= byte_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[tail_dec];
        end
    end

    assign rsp = rsp_reg;

    logic [CW:0] ring_sum;
    assign ring_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above depth");

    // tail always sits count entries past head, modulo depth
    a_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_sum >= (CW+1)'(DEPTH)) ? (tail_reg == IW'(ring_sum - (CW+1)'(DEPTH)))
                                      : (tail_reg == IW'(ring_sum)))
        else $error("head/tail/count out of step");

    a_chk_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chk_clear |=> (count_reg == '0 && head_reg == '0))
        else $error("check did not drain the queue");

endmodule
